FILE: sv/gcc_pkg.sv
// gcc_pkg: shared constants and helpers for the windowed GC-content counter.
// Used by the channel interfaces and by windowed_gc_content_counter.
// No dependencies.
`default_nettype none

package gcc_pkg;

    // Widths of the tallies, the chunk number and the Q8 percentage
    localparam int COUNT_BITS  = 24;
    localparam int INDEX_BITS  = 32;
    localparam int BYTE_BITS   = 8;
    localparam int PCT_BITS    = 15;
    localparam int FRAC_BITS   = 8;
    localparam int SCALE_BITS  = 7;
    localparam int PCT_SCALE   = 100;
    localparam int CHUNK_RESET = 1000;

    // Restoring divider: one quotient bit per step
    localparam int DIV_STEPS = PCT_BITS;
    localparam int STEP_BITS = $clog2(DIV_STEPS);

    // Counted characters
    localparam logic [BYTE_BITS-1:0] ASCII_A = 8'h41;
    localparam logic [BYTE_BITS-1:0] ASCII_T = 8'h54;
    localparam logic [BYTE_BITS-1:0] ASCII_C = 8'h43;
    localparam logic [BYTE_BITS-1:0] ASCII_G = 8'h47;

    // Saturating increment of a tally
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: sv/gcc_if.sv
// Valid/ready channel interfaces of the windowed GC-content counter:
// sequence byte input, chunk report output and chunk size write port.
// Depends on gcc_pkg.
`default_nettype none

interface gcc_in_if import gcc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] base_byte;
    logic                 end_of_input;

    modport source(output valid, output base_byte, output end_of_input, input ready);
    modport sink(input valid, input base_byte, input end_of_input, output ready);
endinterface

interface gcc_out_if import gcc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] chunk_number;
    logic [COUNT_BITS-1:0] adenine_count;
    logic [COUNT_BITS-1:0] thymine_count;
    logic [COUNT_BITS-1:0] cytosine_count;
    logic [COUNT_BITS-1:0] guanine_count;
    logic [COUNT_BITS-1:0] bases_in_chunk;
    logic [PCT_BITS-1:0]   gc_percent_q8;
    logic                  empty_chunk;
    logic                  final_chunk;

    modport source(output valid, output chunk_number, output adenine_count,
                   output thymine_count, output cytosine_count, output guanine_count,
                   output bases_in_chunk, output gc_percent_q8, output empty_chunk,
                   output final_chunk, input ready);
    modport sink(input valid, input chunk_number, input adenine_count,
                 input thymine_count, input cytosine_count, input guanine_count,
                 input bases_in_chunk, input gc_percent_q8, input empty_chunk,
                 input final_chunk, output ready);
endinterface

interface gcc_cfg_if import gcc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] bases_per_chunk;

    modport source(output valid, output bases_per_chunk, input ready);
    modport sink(input valid, input bases_per_chunk, output ready);
endinterface

`default_nettype wire

FILE: sv/windowed_gc_content_counter.sv
// Windowed GC-content counter: counts A/T/C/G per chunk and reports each chunk.
// A byte that does not close a chunk is counted without a report. A report takes a
// multiply state, 15 steps of the shared restoring divider and an output load; input
// is ready again once it is loaded, or once both are loaded when one byte causes both.
// The output register lets a report wait while the next byte is counted.
// Reset (i_rst_n low, synchronous): tallies 0, chunk number 1, chunk size 1000.
`default_nettype none

module windowed_gc_content_counter import gcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gcc_cfg_if.sink   i_cfg,
    gcc_in_if.sink    i_in,
    gcc_out_if.source o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int GC_BITS   = COUNT_BITS + 1;
    localparam int PROD_BITS = GC_BITS + SCALE_BITS;
    localparam int DVD_BITS  = PROD_BITS + FRAC_BITS;

    // Sequencer and tallies
    logic [1:0]            r_state, n_state;
    logic [COUNT_BITS-1:0] r_bases_per_chunk;
    logic [COUNT_BITS-1:0] r_a, r_t, r_c, r_g, r_total;
    logic [COUNT_BITS-1:0] n_a, n_t, n_c, n_g, n_total;
    logic [INDEX_BITS-1:0] r_index, n_index;
    logic                  r_pend_last, n_pend_last;

    // Snapshot of the chunk under report
    logic [COUNT_BITS-1:0] r_rep_a, r_rep_t, r_rep_c, r_rep_g, r_rep_total;
    logic [INDEX_BITS-1:0] r_rep_index;
    logic                  r_rep_final;

    // Divider
    logic [COUNT_BITS-1:0] r_rem;
    logic [PCT_BITS-1:0]   r_acc;
    logic [STEP_BITS-1:0]  r_cnt;

    // Output register
    logic                  r_out_valid;
    logic [INDEX_BITS-1:0] r_o_index;
    logic [COUNT_BITS-1:0] r_o_a, r_o_t, r_o_c, r_o_g, r_o_total;
    logic [PCT_BITS-1:0]   r_o_pct;
    logic                  r_o_empty;
    logic                  r_o_final;

    logic                  w_in_acc;
    logic                  w_full;
    logic                  w_out_free;
    logic                  w_snap;
    logic                  w_snap_new;
    logic                  w_snap_final;
    logic [COUNT_BITS-1:0] w_base_a, w_base_t, w_base_c, w_base_g, w_base_total;
    logic [COUNT_BITS-1:0] w_cnt_a, w_cnt_t, w_cnt_c, w_cnt_g, w_cnt_total;
    logic [GC_BITS-1:0]    w_gc;
    logic [PROD_BITS-1:0]  w_prod;
    logic [DVD_BITS-1:0]   w_dvd;
    logic [GC_BITS-1:0]    w_trial;
    logic [GC_BITS-1:0]    w_diff;
    logic                  w_ge;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_full      = (r_total >= r_bases_per_chunk);
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Count the byte into the tallies, starting from zero when the chunk closes
    always_comb begin
        w_base_a     = w_full ? '0 : r_a;
        w_base_t     = w_full ? '0 : r_t;
        w_base_c     = w_full ? '0 : r_c;
        w_base_g     = w_full ? '0 : r_g;
        w_base_total = w_full ? '0 : r_total;
        w_cnt_a      = w_base_a;
        w_cnt_t      = w_base_t;
        w_cnt_c      = w_base_c;
        w_cnt_g      = w_base_g;
        w_cnt_total  = w_base_total;
        case (i_in.base_byte)
            ASCII_A: begin
                w_cnt_a     = sat_inc(w_base_a);
                w_cnt_total = sat_inc(w_base_total);
            end
            ASCII_T: begin
                w_cnt_t     = sat_inc(w_base_t);
                w_cnt_total = sat_inc(w_base_total);
            end
            ASCII_C: begin
                w_cnt_c     = sat_inc(w_base_c);
                w_cnt_total = sat_inc(w_base_total);
            end
            ASCII_G: begin
                w_cnt_g     = sat_inc(w_base_g);
                w_cnt_total = sat_inc(w_base_total);
            end
            default: ;
        endcase
    end

    // Sequencer: count, snapshot a chunk, divide, load the result
    always_comb begin
        n_state      = r_state;
        n_a          = r_a;
        n_t          = r_t;
        n_c          = r_c;
        n_g          = r_g;
        n_total      = r_total;
        n_index      = r_index;
        n_pend_last  = r_pend_last;
        w_snap       = 1'b0;
        w_snap_new   = 1'b0;
        w_snap_final = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_a     = w_cnt_a;
                    n_t     = w_cnt_t;
                    n_c     = w_cnt_c;
                    n_g     = w_cnt_g;
                    n_total = w_cnt_total;
                    if (w_full) begin
                        // Report the full chunk first; a final report follows if this byte ends the input
                        w_snap      = 1'b1;
                        n_index     = (&r_index) ? r_index : r_index + 1'b1;
                        n_pend_last = i_in.end_of_input;
                        n_state     = S_MUL;
                    end else if (i_in.end_of_input) begin
                        w_snap       = 1'b1;
                        w_snap_new   = 1'b1;
                        w_snap_final = 1'b1;
                        n_a          = '0;
                        n_t          = '0;
                        n_c          = '0;
                        n_g          = '0;
                        n_total      = '0;
                        n_index      = INDEX_BITS'(1);
                        n_state      = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == STEP_BITS'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    if (r_pend_last) begin
                        w_snap       = 1'b1;
                        w_snap_final = 1'b1;
                        n_a          = '0;
                        n_t          = '0;
                        n_c          = '0;
                        n_g          = '0;
                        n_total      = '0;
                        n_index      = INDEX_BITS'(1);
                        n_pend_last  = 1'b0;
                        n_state      = S_MUL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_bases_per_chunk <= COUNT_BITS'(CHUNK_RESET);
            r_a               <= '0;
            r_t               <= '0;
            r_c               <= '0;
            r_g               <= '0;
            r_total           <= '0;
            r_index           <= INDEX_BITS'(1);
            r_pend_last       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a         <= n_a;
            r_t         <= n_t;
            r_c         <= n_c;
            r_g         <= n_g;
            r_total     <= n_total;
            r_index     <= n_index;
            r_pend_last <= n_pend_last;
            if (i_cfg.valid) begin
                r_bases_per_chunk <= i_cfg.bases_per_chunk;
            end
        end
    end

    // Hold the chunk under report
    always_ff @(posedge i_clk) begin
        if (w_snap) begin
            r_rep_a     <= w_snap_new ? w_cnt_a : r_a;
            r_rep_t     <= w_snap_new ? w_cnt_t : r_t;
            r_rep_c     <= w_snap_new ? w_cnt_c : r_c;
            r_rep_g     <= w_snap_new ? w_cnt_g : r_g;
            r_rep_total <= w_snap_new ? w_cnt_total : r_total;
            r_rep_index <= r_index;
            r_rep_final <= w_snap_final;
        end
    end

    // Dividend (C+G) * 100 * 256; quotient fits 15 bits since C+G <= total
    assign w_gc   = {1'b0, r_rep_c} + {1'b0, r_rep_g};
    assign w_prod = PROD_BITS'(w_gc) * PROD_BITS'(PCT_SCALE);
    assign w_dvd  = {w_prod, {FRAC_BITS{1'b0}}};

    // One restoring step: shift in a dividend bit, subtract when it fits
    assign w_trial = {r_rem, r_acc[PCT_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_rep_total});
    assign w_diff  = w_trial - {1'b0, r_rep_total};

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL: begin
                r_rem <= w_dvd[COUNT_BITS+PCT_BITS-1:PCT_BITS];
                r_acc <= w_dvd[PCT_BITS-1:0];
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
                r_acc <= {r_acc[PCT_BITS-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    // Output register: load a finished report, drop valid when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_index <= r_rep_index;
            r_o_a     <= r_rep_a;
            r_o_t     <= r_rep_t;
            r_o_c     <= r_rep_c;
            r_o_g     <= r_rep_g;
            r_o_total <= r_rep_total;
            r_o_empty <= (r_rep_total == '0);
            r_o_pct   <= (r_rep_total == '0) ? '0 : r_acc;
            r_o_final <= r_rep_final;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.chunk_number   = r_o_index;
    assign o_out.adenine_count  = r_o_a;
    assign o_out.thymine_count  = r_o_t;
    assign o_out.cytosine_count = r_o_c;
    assign o_out.guanine_count  = r_o_g;
    assign o_out.bases_in_chunk = r_o_total;
    assign o_out.gc_percent_q8  = r_o_pct;
    assign o_out.empty_chunk    = r_o_empty;
    assign o_out.final_chunk    = r_o_final;

    // A byte that finds the chunk full starts a report
    a_full_starts_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_full |=> r_state == S_MUL)
        else $error("full chunk did not start a report");

    // The divider never runs past its last step
    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt <= STEP_BITS'(DIV_STEPS - 1))
        else $error("divider step count overran");

    // A reported total is the sum of its four tallies
    a_total_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((COUNT_BITS+2)'(r_o_a) + (COUNT_BITS+2)'(r_o_t)
                         + (COUNT_BITS+2)'(r_o_c) + (COUNT_BITS+2)'(r_o_g))
                        == (COUNT_BITS+2)'(r_o_total))
        else $error("reported total differs from tally sum");

    // The percentage never exceeds 100 percent
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_o_pct <= PCT_BITS'(PCT_SCALE << FRAC_BITS))
        else $error("percentage out of range");

    // After the last report of an item the block takes input again
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && w_out_free && !r_pend_last |=> i_in.ready)
        else $error("block did not return to ready");

endmodule

`default_nettype wire

FILE: tb/sv/gcc_tb_pkg.sv
// gcc_tb_pkg: chunk report type and scoreboard for the GC-content counter bench.
// Predicts chunk reports from accepted sequence bytes and checks received reports.
// Depends on gcc_pkg.

package gcc_tb_pkg;
    import gcc_pkg::*;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [INDEX_BITS-1:0] chunk_number;
        logic [COUNT_BITS-1:0] adenine;
        logic [COUNT_BITS-1:0] thymine;
        logic [COUNT_BITS-1:0] cytosine;
        logic [COUNT_BITS-1:0] guanine;
        logic [COUNT_BITS-1:0] bases;
        logic [PCT_BITS-1:0]   gc_q8;
        logic                  is_empty;
        logic                  is_final;
    } chunk_report_t;

    class chunk_tally_scoreboard;
        logic [COUNT_BITS-1:0] bases_per_chunk;
        logic [COUNT_BITS-1:0] base_total;
        logic [COUNT_BITS-1:0] a_cnt;
        logic [COUNT_BITS-1:0] t_cnt;
        logic [COUNT_BITS-1:0] c_cnt;
        logic [COUNT_BITS-1:0] g_cnt;
        logic [INDEX_BITS-1:0] chunk_idx;
        chunk_report_t         expected_q[$];
        int unsigned           mismatches;
        int unsigned           bytes_seen;
        int unsigned           reports_seen;

        function new();
            bases_per_chunk = COUNT_BITS'(CHUNK_RESET);
            chunk_idx       = 1;
            mismatches      = 0;
            bytes_seen      = 0;
            reports_seen    = 0;
            clear_tallies();
        endfunction

        function void set_bases_per_chunk(logic [COUNT_BITS-1:0] size);
            bases_per_chunk = size;
        endfunction

        function void clear_tallies();
            base_total = '0;
            a_cnt      = '0;
            t_cnt      = '0;
            c_cnt      = '0;
            g_cnt      = '0;
        endfunction

        // Saturate at the top of the tally range
        function logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
            return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
        endfunction

        // Build the report of the chunk as it stands now
        function chunk_report_t summarize(logic is_final);
            chunk_report_t r;
            logic [63:0]   gc_scaled;
            gc_scaled      = (64'(c_cnt) + 64'(g_cnt)) * 64'(PCT_SCALE << FRAC_BITS);
            r.chunk_number = chunk_idx;
            r.adenine      = a_cnt;
            r.thymine      = t_cnt;
            r.cytosine     = c_cnt;
            r.guanine      = g_cnt;
            r.bases        = base_total;
            r.is_empty     = (base_total == '0);
            r.gc_q8        = r.is_empty ? '0 : PCT_BITS'(gc_scaled / 64'(base_total));
            r.is_final     = is_final;
            return r;
        endfunction

        // Advance the chunk state by one accepted item and queue its reports
        function void note_byte(logic [BYTE_BITS-1:0] b, logic eoi);
            bytes_seen++;
            if (base_total >= bases_per_chunk) begin
                expected_q.push_back(summarize(1'b0));
                clear_tallies();
                if (chunk_idx != {INDEX_BITS{1'b1}}) chunk_idx++;
            end
            case (b)
                ASCII_A: begin a_cnt = bump(a_cnt); base_total = bump(base_total); end
                ASCII_T: begin t_cnt = bump(t_cnt); base_total = bump(base_total); end
                ASCII_C: begin c_cnt = bump(c_cnt); base_total = bump(base_total); end
                ASCII_G: begin g_cnt = bump(g_cnt); base_total = bump(base_total); end
                default: ;
            endcase
            if (eoi) begin
                expected_q.push_back(summarize(1'b1));
                clear_tallies();
                chunk_idx = 1;
            end
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("MISMATCH at %0t, report %0d: %s expected 0x%0h got 0x%0h",
                         $time, reports_seen, what, want, got);
        endtask

        task compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) report_mismatch(name, want, got);
        endtask

        // Check one received report against the oldest prediction
        task check_report(chunk_report_t got);
            chunk_report_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected report, chunk_number", '0, got.chunk_number);
                return;
            end
            want = expected_q.pop_front();
            reports_seen++;
            compare_field("chunk_number", want.chunk_number, got.chunk_number);
            compare_field("adenine_count", want.adenine, got.adenine);
            compare_field("thymine_count", want.thymine, got.thymine);
            compare_field("cytosine_count", want.cytosine, got.cytosine);
            compare_field("guanine_count", want.guanine, got.guanine);
            compare_field("bases_in_chunk", want.bases, got.bases);
            compare_field("gc_percent_q8", want.gc_q8, got.gc_q8);
            compare_field("empty_chunk", want.is_empty, got.is_empty);
            compare_field("final_chunk", want.is_final, got.is_final);
        endtask
    endclass

endpackage

FILE: tb/sv/windowed_gc_content_counter_test.sv
// windowed_gc_content_counter_test: drives sequence bytes and chunk size writes
// into windowed_gc_content_counter and checks every chunk report.
// Depends on gcc_pkg, the gcc channel interfaces and gcc_tb_pkg.

module windowed_gc_content_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gcc_pkg::*;
    import gcc_tb_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [BYTE_BITS-1:0] NEWLINE        = 8'h0A;
    localparam logic [BYTE_BITS-1:0] HEADER_MARK    = 8'h3E;
    localparam logic [BYTE_BITS-1:0] LOWER_CASE_BIT = 8'h20;
    localparam logic [COUNT_BITS-1:0] CHUNK_MAX     = {COUNT_BITS{1'b1}};

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    chunk_tally_scoreboard sb;
    chunk_report_t         seen_report;
    int unsigned           send_idle_pct;
    int unsigned           recv_stall_pct;
    int unsigned           idle_cycles;
    int unsigned           cfg_writes;

    gcc_in_if  in_bus ();
    gcc_out_if out_bus ();
    gcc_cfg_if cfg_bus ();

    windowed_gc_content_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #1 i_clk = ~i_clk;

    // Randomize the report ready at each falling edge
    always @(negedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each accepted report
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            seen_report.chunk_number = out_bus.chunk_number;
            seen_report.adenine      = out_bus.adenine_count;
            seen_report.thymine      = out_bus.thymine_count;
            seen_report.cytosine     = out_bus.cytosine_count;
            seen_report.guanine      = out_bus.guanine_count;
            seen_report.bases        = out_bus.bases_in_chunk;
            seen_report.gc_q8        = out_bus.gc_percent_q8;
            seen_report.is_empty     = out_bus.empty_chunk;
            seen_report.is_final     = out_bus.final_chunk;
            sb.check_report(seen_report);
        end
    end

    // Abort when no channel moves an item for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("No item moved for %0d cycles, %0d reports outstanding",
                     idle_cycles, sb.expected_q.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic set_idle_mode(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 65; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            IDLE_BOTH:     begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
    endtask

    // Offer one item, hold it until accepted, return at the next falling edge
    task automatic send_item(input logic [BYTE_BITS-1:0] b, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.base_byte    <= b;
        in_bus.end_of_input <= eoi;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        sb.note_byte(b, eoi);
        @(negedge i_clk);
    endtask

    // Send a string as one sequence, ending the input on its last character
    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
    endtask

    // Drop valid, wait for every report, then let the block settle
    task automatic drain();
        in_bus.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_bases_per_chunk(input logic [COUNT_BITS-1:0] size);
        cfg_bus.valid           <= 1'b1;
        cfg_bus.bases_per_chunk <= size;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        sb.set_bases_per_chunk(size);
        cfg_writes++;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly uppercase bases, with lowercase, line breaks, headers and raw bytes
    function automatic logic [BYTE_BITS-1:0] pick_byte();
        logic [BYTE_BITS-1:0] letters [4];
        int unsigned          roll;
        letters = '{ASCII_A, ASCII_T, ASCII_C, ASCII_G};
        roll = $urandom_range(99);
        if (roll < 80) return letters[$urandom_range(3)];
        if (roll < 88) return letters[$urandom_range(3)] | LOWER_CASE_BIT;
        if (roll < 92) return NEWLINE;
        if (roll < 95) return HEADER_MARK;
        return BYTE_BITS'($urandom_range(255));
    endfunction

    // Random sequences under one chunk size; budget counts items
    task automatic run_phase(input logic [COUNT_BITS-1:0] size, input idle_mode_e mode,
                             input int unsigned budget);
        logic [BYTE_BITS-1:0] b;
        logic                 eoi;
        int unsigned          run_len;
        int unsigned          k;
        write_bases_per_chunk(size);
        set_idle_mode(mode);
        while (budget > 0) begin
            run_len = $urandom_range(1, 40);
            for (k = 0; k < run_len && budget > 0; k++) begin
                b   = pick_byte();
                eoi = (k == run_len - 1) || ($urandom_range(99) == 0);
                budget--;
                send_item(b, eoi);
            end
        end
        drain();
    endtask

    initial begin
        sb                      = new();
        i_rst_n                 = 1'b0;
        in_bus.valid            = 1'b0;
        in_bus.base_byte        = '0;
        in_bus.end_of_input     = 1'b0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.bases_per_chunk = '0;
        out_bus.ready           = 1'b0;
        idle_cycles             = 0;
        cfg_writes              = 0;
        set_idle_mode(IDLE_NONE);
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset chunk size: raw extremes, header and lowercase noise, two sequences
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text(">a\nATCGG");
        send_text("x");
        drain();

        // Zero chunk size: every byte finds the chunk full
        write_bases_per_chunk('0);
        send_text("ACn");
        drain();

        // Two-base chunks: full chunk and input end on the same byte
        write_bases_per_chunk(COUNT_BITS'(2));
        send_text("GCATG");
        drain();

        // Largest chunk size: only the final reports come out
        write_bases_per_chunk(CHUNK_MAX);
        send_text("TA");
        send_text("G");
        drain();

        run_phase(COUNT_BITS'(1), IDLE_NONE, 150);
        run_phase(COUNT_BITS'(0), IDLE_SENDER, 100);
        run_phase(COUNT_BITS'($urandom_range(2, 12)), IDLE_RECEIVER, 150);
        run_phase(CHUNK_MAX, IDLE_BOTH, 100);
        run_phase(COUNT_BITS'($urandom_range(13, 40)), IDLE_BOTH, 150);
        run_phase(COUNT_BITS'($urandom_range(1, 5)), IDLE_NONE, 100);

        $display("Sent %0d sequence bytes, checked %0d chunk reports, %0d mismatches",
                 sb.bytes_seen, sb.reports_seen, sb.mismatches);
        $display("Chunk size written %0d times, from zero up to full scale", cfg_writes);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
